@@ rtl/aclfu_pkg.sv @@
// Package for the LFU write-back cache: fixed geometry, access codes and the
// structs that pass between the line store, the backing memory and the top level.
// No dependencies.
`default_nettype none

package aclfu_pkg;

	localparam int BYTES_PER_LINE = 4;
	localparam int NUM_BLOCKS     = 32;
	localparam int OFF_W          = $clog2(BYTES_PER_LINE);
	localparam int TAG_W          = $clog2(NUM_BLOCKS);
	localparam int ADDR_W         = OFF_W + TAG_W;
	localparam int ROW_W          = 8 * BYTES_PER_LINE;
	localparam int CTR_W          = 16;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [TAG_W-1:0] tag;
		logic [OFF_W-1:0] off;
		logic [7:0]       wdata;
	} access_t;

	typedef struct packed {
		logic             en;
		logic [TAG_W-1:0] row;
		logic [ROW_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       hit;
		logic [2:0] line_used;
		logic       wrote_back;
	} lookup_t;

endpackage

`default_nettype wire

@@ rtl/aclfu_backing_mem.sv @@
// Backing memory, one block per row, with a registered read port and one write port.
// Per-row valid flags make unwritten rows read as zero. Depends on aclfu_pkg.
`default_nettype none

module aclfu_backing_mem
	import aclfu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [TAG_W-1:0] rd_row,
	input  wire mem_wr_t          wr,
	output logic      [ROW_W-1:0] rd_data
);

	logic [ROW_W-1:0]      mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] row_vld_q;
	logic [ROW_W-1:0]      rd_q;
	logic                  rd_vld_q;
	logic                  fwd_q;
	logic [ROW_W-1:0]      fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
		if (rd_en && wr.en) begin
			fwd_data_q <= wr.data;
		end
	end

	// A write-back to the row being read in the same cycle is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			fwd_q     <= 1'b0;
		end else begin
			if (wr.en) begin
				row_vld_q[wr.row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_row];
				fwd_q    <= wr.en && (wr.row == rd_row);
			end
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

`default_nettype wire

@@ rtl/aclfu_lines.sv @@
// Cache line store: tag match, free-line and LFU victim selection, line update.
// Depends on aclfu_pkg; block data comes from aclfu_backing_mem.
`default_nettype none

module aclfu_lines
	import aclfu_pkg::*;
#(
	parameter int NUM_LINES  = 8,
	parameter int COUNT_BITS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire access_t          acc,
	input  wire logic [ROW_W-1:0] blk_data,
	input  wire logic             upd,
	output lookup_t               res,
	output mem_wr_t               wr
);

	localparam int LW = $clog2(NUM_LINES);

	logic [NUM_LINES-1:0]  valid_q;
	logic [NUM_LINES-1:0]  dirty_q;
	logic [TAG_W-1:0]      tag_q   [NUM_LINES];
	logic [COUNT_BITS-1:0] cnt_q   [NUM_LINES];
	logic [ROW_W-1:0]      bytes_q [NUM_LINES];

	logic [NUM_LINES-1:0]  hit_vec;
	logic [NUM_LINES-1:0]  free_vec;
	logic [NUM_LINES-1:0]  vic_vec;
	logic                  hit;
	logic                  any_free;
	logic [LW-1:0]         sel;
	logic [ROW_W-1:0]      old_bytes;
	logic [ROW_W-1:0]      base;
	logic [ROW_W-1:0]      new_bytes;
	logic [7:0]            old_byte;
	logic                  changed;
	logic                  new_dirty;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  wb;
	logic [LW+2:0]         sel_ext;

	function automatic logic [LW-1:0] first_set(input logic [NUM_LINES-1:0] v);
		logic [LW-1:0] idx;
		idx = '0;
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = LW'(i);
			end
		end
		return idx;
	endfunction

	// A line is the victim when its count is below every lower-indexed count
	// and not above any higher-indexed count, so the lowest index wins ties.
	always_comb begin
		logic ok;
		for (int i = 0; i < NUM_LINES; i++) begin
			hit_vec[i]  = valid_q[i] && (tag_q[i] == acc.tag);
			free_vec[i] = !valid_q[i];
			ok = 1'b1;
			for (int j = 0; j < NUM_LINES; j++) begin
				if (j < i) begin
					ok = ok && (cnt_q[i] < cnt_q[j]);
				end else if (j > i) begin
					ok = ok && (cnt_q[i] <= cnt_q[j]);
				end
			end
			vic_vec[i] = ok;
		end
	end

	always_comb begin
		hit      = |hit_vec;
		any_free = |free_vec;
		if (hit) begin
			sel = first_set(hit_vec);
		end else if (any_free) begin
			sel = first_set(free_vec);
		end else begin
			sel = first_set(vic_vec);
		end

		old_bytes = bytes_q[sel];
		wb        = !hit && !any_free && dirty_q[sel];
		base      = hit ? old_bytes : blk_data;
		old_byte  = base[{acc.off, 3'b000} +: 8];
		changed   = (acc.kind == KIND_WRITE) && (!hit || (old_byte != acc.wdata));

		new_bytes = base;
		if (acc.kind == KIND_WRITE) begin
			new_bytes[{acc.off, 3'b000} +: 8] = acc.wdata;
		end

		new_dirty = hit ? (dirty_q[sel] | changed) : changed;

		if (!hit) begin
			new_cnt = '0;
		end else if (cnt_q[sel] == {COUNT_BITS{1'b1}}) begin
			new_cnt = cnt_q[sel];
		end else begin
			new_cnt = cnt_q[sel] + 1'b1;
		end

		sel_ext        = (LW + 3)'(sel);
		res.read_data  = (acc.kind == KIND_WRITE) ? acc.wdata : old_byte;
		res.hit        = hit;
		res.line_used  = sel_ext[2:0];
		res.wrote_back = wb;

		wr.en   = upd && wb;
		wr.row  = tag_q[sel];
		wr.data = old_bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
		end else if (upd) begin
			valid_q[sel] <= 1'b1;
			dirty_q[sel] <= new_dirty;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			tag_q[sel]   <= acc.tag;
			cnt_q[sel]   <= new_cnt;
			bytes_q[sel] <= new_bytes;
		end
	end

endmodule

`default_nettype wire

@@ rtl/assoc_cache_lfu_writeback_unit.sv @@
// Top level of the fully associative LFU write-back cache: input register,
// access counters and result register. Uses aclfu_pkg, aclfu_lines, aclfu_backing_mem.
//
//   channel | signals                                   | moves
//   --------+-------------------------------------------+--------------------------
//   in      | in_valid, in_stall, kind, address, write_data | one access request
//   out     | out_valid, out_stall, read_data, hit,     | one result per request
//           | line_used, wrote_back, *_count            |
//
// A request is registered together with the backing-memory row read for its block;
// from that request stage the lookup, fill, write-back and line update are done and
// the result register is loaded; a request is taken every cycle unless the output stalls.
// Reset clears line valid/dirty flags, the backing-memory row flags and counters.
// A stalled result holds the request stage, which then stalls the input.
`default_nettype none

module assoc_cache_lfu_writeback_unit
	import aclfu_pkg::*;
#(
	parameter int NUM_LINES  = 8,
	parameter int COUNT_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              kind,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [7:0]        write_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        read_data,
	output logic                   hit,
	output logic      [2:0]        line_used,
	output logic                   wrote_back,
	output logic      [CTR_W-1:0]  read_hit_count,
	output logic      [CTR_W-1:0]  read_miss_count,
	output logic      [CTR_W-1:0]  write_hit_count,
	output logic      [CTR_W-1:0]  write_miss_count
);

	logic             valid_s1;
	access_t          acc_s1;
	logic             adv;
	logic             take;
	logic [ROW_W-1:0] blk_data;
	lookup_t          res;
	mem_wr_t          wr;
	logic             out_valid_q;
	lookup_t          res_q;
	logic [CTR_W-1:0] rh_q;
	logic [CTR_W-1:0] rm_q;
	logic [CTR_W-1:0] wh_q;
	logic [CTR_W-1:0] wm_q;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	aclfu_backing_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_row  (address[OFF_W +: TAG_W]),
		.wr      (wr),
		.rd_data (blk_data)
	);

	aclfu_lines #(
		.NUM_LINES  (NUM_LINES),
		.COUNT_BITS (COUNT_BITS)
	) u_lines (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc_s1),
		.blk_data (blk_data),
		.upd      (adv),
		.res      (res),
		.wr       (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_s1.kind  <= kind;
			acc_s1.tag   <= address[OFF_W +: TAG_W];
			acc_s1.off   <= address[OFF_W-1:0];
			acc_s1.wdata <= write_data;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	// Counters move only when a result is loaded, so they always match it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rh_q        <= '0;
			rm_q        <= '0;
			wh_q        <= '0;
			wm_q        <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (acc_s1.kind == KIND_READ && res.hit && rh_q != {CTR_W{1'b1}}) begin
					rh_q <= rh_q + 1'b1;
				end
				if (acc_s1.kind == KIND_READ && !res.hit && rm_q != {CTR_W{1'b1}}) begin
					rm_q <= rm_q + 1'b1;
				end
				if (acc_s1.kind == KIND_WRITE && res.hit && wh_q != {CTR_W{1'b1}}) begin
					wh_q <= wh_q + 1'b1;
				end
				if (acc_s1.kind == KIND_WRITE && !res.hit && wm_q != {CTR_W{1'b1}}) begin
					wm_q <= wm_q + 1'b1;
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign read_data        = res_q.read_data;
	assign hit              = res_q.hit;
	assign line_used        = res_q.line_used;
	assign wrote_back       = res_q.wrote_back;
	assign read_hit_count   = rh_q;
	assign read_miss_count  = rm_q;
	assign write_hit_count  = wh_q;
	assign write_miss_count = wm_q;

endmodule

`default_nettype wire
